// ===== hdl/srq_pkg.sv =====
// shared types and constants of the sorted ready queue
package srq_pkg;

    localparam int SRQ_DEPTH  = 16;
    localparam int ID_W       = 10;
    localparam int PRI_W      = 8;
    localparam int LEN_W      = 16;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 40;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic {
        SORT_PRIORITY = 1'b0,
        SORT_LENGTH   = 1'b1
    } sort_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic [LEN_W-1:0] len;
    } entry_t;

    typedef struct packed {
        logic   push_go;
        logic   pop_go;
        sort_t  sort_mode;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ===== hdl/srq_cell.sv =====
// one slot of the sorted queue: compares against the new job and shifts with its neighbors
module srq_cell (
    input  logic               aclk,
    input  srq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               left_ins,
    input  srq_pkg::entry_t    left_entry,
    input  srq_pkg::entry_t    right_entry,
    output logic               ins,
    output srq_pkg::entry_t    entry
);

    srq_pkg::entry_t entry_reg;
    srq_pkg::entry_t entry_next;
    logic            worse;

    always_comb begin
        if (ctrl.sort_mode == srq_pkg::SORT_PRIORITY) begin
            worse = entry_reg.pri < ctrl.new_entry.pri;
        end else begin
            worse = entry_reg.len > ctrl.new_entry.len;
        end
        ins = left_ins || !occupied || worse;
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.push_go && ins) begin
            entry_next = left_ins ? left_entry : ctrl.new_entry;
        end else if (ctrl.pop_go) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== hdl/sorted_ready_queue_core.sv =====
// top level of the sorted ready queue: cell row, occupancy count and result register
//
// A job ready queue kept sorted by one key: with sort_mode 0 the highest job_priority
// leaves first, with sort_mode 1 the smallest job_length; equal keys leave in arrival
// order. Each input transfer is a push (tuser 0) or a pop (tuser 1) and gives exactly
// one result transfer with the status, the popped job and the entry count. The queue
// is a row of QUEUE_DEPTH slot cells that all compare against the pushed job and shift
// toward their neighbors in the same cycle: one input transfer per cycle is accepted
// while the output register is empty or being read out, and its result sits in the
// output register the cycle after acceptance. Changing sort_mode keeps the stored
// order; only later pushes use it.
module sorted_ready_queue_core #(
    parameter int QUEUE_DEPTH = srq_pkg::SRQ_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,   // sort_mode
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srq_pkg::S_DATA_W-1:0]  s_tdata,     // job_id, job_priority, job_length
    input  logic                          s_tuser,     // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // head_id, head_priority, head_length, entry_count
    output logic [srq_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [srq_pkg::STATUS_W-1:0]  m_tuser      // status
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    srq_pkg::sort_t   sort_mode_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             m_valid_reg;
    srq_pkg::status_t status_reg;
    srq_pkg::status_t status_next;
    srq_pkg::entry_t  head_reg;
    srq_pkg::entry_t  head_next;
    logic [srq_pkg::COUNT_W-1:0] entry_count_reg;
    logic [CW+srq_pkg::COUNT_W-1:0] count_ext;

    logic             s_fire;
    logic             full;
    logic             empty;
    srq_pkg::op_t     op;
    srq_pkg::cell_ctrl_t ctrl;

    srq_pkg::entry_t  cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_ins;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign op       = srq_pkg::op_t'(s_tuser);
    assign full     = count_reg == CW'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;

    always_comb begin
        ctrl.push_go       = s_fire && (op == srq_pkg::OP_PUSH) && !full;
        ctrl.pop_go        = s_fire && (op == srq_pkg::OP_POP) && !empty;
        ctrl.sort_mode     = sort_mode_reg;
        ctrl.new_entry.id  = s_tdata[srq_pkg::ID_W-1:0];
        ctrl.new_entry.pri = s_tdata[srq_pkg::ID_W +: srq_pkg::PRI_W];
        ctrl.new_entry.len = s_tdata[srq_pkg::ID_W+srq_pkg::PRI_W +: srq_pkg::LEN_W];
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic            occ;
        logic            l_ins;
        srq_pkg::entry_t l_entry;
        srq_pkg::entry_t r_entry;

        assign occ = count_reg > CW'(i);

        if (i == 0) begin : g_head
            assign l_ins   = 1'b0;
            assign l_entry = ctrl.new_entry;
        end else begin : g_mid
            assign l_ins   = cell_ins[i-1];
            assign l_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign r_entry = cell_entry[i];
        end else begin : g_body
            assign r_entry = cell_entry[i+1];
        end

        srq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (occ),
            .left_ins    (l_ins),
            .left_entry  (l_entry),
            .right_entry (r_entry),
            .ins         (cell_ins[i]),
            .entry       (cell_entry[i])
        );
    end

    always_comb begin
        count_next  = count_reg;
        status_next = srq_pkg::ST_PUSHED;
        head_next   = '0;
        if (op == srq_pkg::OP_PUSH) begin
            if (full) begin
                status_next = srq_pkg::ST_FULL;
            end else begin
                count_next  = count_reg + CW'(1);
            end
        end else begin
            if (empty) begin
                status_next = srq_pkg::ST_EMPTY;
            end else begin
                status_next = srq_pkg::ST_POPPED;
                head_next   = cell_entry[0];
                count_next  = count_reg - CW'(1);
            end
        end
    end

    assign count_ext = {{srq_pkg::COUNT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sort_mode_reg <= srq_pkg::SORT_PRIORITY;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                sort_mode_reg <= srq_pkg::sort_t'(cfg_wdata);
            end
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg      <= status_next;
            head_reg        <= head_next;
            entry_count_reg <= count_ext[srq_pkg::COUNT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, entry_count_reg, head_reg.len, head_reg.pri, head_reg.id};

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_push_count : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push_go |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow occupancy");

    a_pop_count : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop_go |=> count_reg == $past(count_reg) - CW'(1) &&
                        status_reg == srq_pkg::ST_POPPED)
        else $error("pop did not shrink occupancy or report popped");

    a_empty_pop : assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && op == srq_pkg::OP_POP && empty |=>
            status_reg == srq_pkg::ST_EMPTY && head_reg == '0)
        else $error("pop on empty queue reported wrongly");
`endif

endmodule

// ===== tb/tb_top.sv =====
// testbench of the sorted ready queue: directed table, random phases, scoreboard
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = srq_pkg::SRQ_DEPTH;
    localparam int ID_W        = srq_pkg::ID_W;
    localparam int PRI_W       = srq_pkg::PRI_W;
    localparam int LEN_W       = srq_pkg::LEN_W;
    localparam int COUNT_W     = srq_pkg::COUNT_W;
    localparam int S_DATA_W    = srq_pkg::S_DATA_W;
    localparam int M_DATA_W    = srq_pkg::M_DATA_W;
    localparam int STATUS_W    = srq_pkg::STATUS_W;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 1000;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 110;
    localparam int MAX_ROWS    = 32;
    localparam int EXP_SLOTS   = 64;

    typedef struct packed {
        srq_pkg::status_t     status;
        srq_pkg::entry_t      head;
        logic [COUNT_W-1:0]   count;
    } result_t;

    typedef struct {
        srq_pkg::sort_t   sort;
        srq_pkg::op_t     op;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic [LEN_W-1:0] len;
        int               reps;
        bit               typed;
        result_t          res;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // queue model state
    logic [ID_W-1:0]  job_ids  [DEPTH];
    logic [PRI_W-1:0] job_pris [DEPTH];
    logic [LEN_W-1:0] job_lens [DEPTH];
    int               job_count = 0;
    srq_pkg::sort_t   order_key = srq_pkg::SORT_PRIORITY;

    result_t   exp_results [EXP_SLOTS];
    int        exp_wr = 0;
    int        exp_rd = 0;
    stim_row_t job_table [MAX_ROWS];
    int        n_rows = 0;
    int        n_mismatch = 0;
    int        idle_cycles = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;

    sorted_ready_queue_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void serve_job(input srq_pkg::op_t op, input logic [ID_W-1:0] id,
                                      input logic [PRI_W-1:0] pri,
                                      input logic [LEN_W-1:0] len, output result_t r);
        int  pos;
        bit  worse;
        r = '0;
        if (op == srq_pkg::OP_PUSH) begin
            if (job_count >= DEPTH) begin
                r.status = srq_pkg::ST_FULL;
            end else begin
                pos = job_count;
                for (int i = 0; i < job_count; i++) begin
                    worse = (order_key == srq_pkg::SORT_PRIORITY) ? (job_pris[i] < pri)
                                                                  : (job_lens[i] > len);
                    if (pos == job_count && worse)
                        pos = i;
                end
                for (int i = job_count; i > pos; i--) begin
                    job_ids[i]  = job_ids[i-1];
                    job_pris[i] = job_pris[i-1];
                    job_lens[i] = job_lens[i-1];
                end
                job_ids[pos]  = id;
                job_pris[pos] = pri;
                job_lens[pos] = len;
                job_count++;
                r.status = srq_pkg::ST_PUSHED;
            end
        end else begin
            if (job_count == 0) begin
                r.status = srq_pkg::ST_EMPTY;
            end else begin
                r.head.id  = job_ids[0];
                r.head.pri = job_pris[0];
                r.head.len = job_lens[0];
                for (int i = 1; i < job_count; i++) begin
                    job_ids[i-1]  = job_ids[i];
                    job_pris[i-1] = job_pris[i];
                    job_lens[i-1] = job_lens[i];
                end
                job_count--;
                r.status = srq_pkg::ST_POPPED;
            end
        end
        r.count = job_count[COUNT_W-1:0];
    endfunction

    function automatic void add_row(input srq_pkg::sort_t s, input srq_pkg::op_t op,
                                    input logic [ID_W-1:0] id,
                                    input logic [PRI_W-1:0] pri, input logic [LEN_W-1:0] len,
                                    input int reps, input bit typed,
                                    input srq_pkg::status_t st,
                                    input logic [ID_W-1:0] hid, input logic [PRI_W-1:0] hpri,
                                    input logic [LEN_W-1:0] hlen, input int cnt);
        stim_row_t row;
        row.sort  = s;
        row.op    = op;
        row.id    = id;
        row.pri   = pri;
        row.len   = len;
        row.reps  = reps;
        row.typed = typed;
        row.res.status   = st;
        row.res.head.id  = hid;
        row.res.head.pri = hpri;
        row.res.head.len = hlen;
        row.res.count    = cnt[COUNT_W-1:0];
        job_table[n_rows] = row;
        n_rows++;
    endfunction

    task automatic send_job(input srq_pkg::op_t op, input logic [ID_W-1:0] id,
                            input logic [PRI_W-1:0] pri, input logic [LEN_W-1:0] len,
                            input bit typed, input result_t typed_res);
        result_t predicted;
        while (!calm && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-LEN_W-PRI_W-ID_W){1'b0}}, len, pri, id};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        serve_job(op, id, pri, len, predicted);
        exp_results[exp_wr % EXP_SLOTS] = typed ? typed_res : predicted;
        exp_wr++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (exp_wr != exp_rd)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_order(input srq_pkg::sort_t s);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge aclk);
        order_key = s;
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random(input int push_pct);
        srq_pkg::op_t     op;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic [LEN_W-1:0] len;
        int               style;
        op    = ($urandom_range(99) < push_pct) ? srq_pkg::OP_PUSH : srq_pkg::OP_POP;
        id    = ID_W'($urandom_range(1023));
        style = $urandom_range(9);
        if (style < 4) begin
            pri = PRI_W'($urandom_range(3));
            len = LEN_W'($urandom_range(3));
        end else if (style < 8) begin
            pri = PRI_W'($urandom_range(255));
            len = LEN_W'($urandom_range(65535));
        end else begin
            pri = $urandom_range(1) ? 8'hff : 8'h00;
            len = $urandom_range(1) ? 16'hffff : 16'h0000;
        end
        send_job(op, id, pri, len, 1'b0, '0);
    endtask

    // result side ready
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 16);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status   = srq_pkg::status_t'(m_tuser);
            got.head.id  = m_tdata[ID_W-1:0];
            got.head.pri = m_tdata[ID_W +: PRI_W];
            got.head.len = m_tdata[ID_W+PRI_W +: LEN_W];
            got.count    = m_tdata[ID_W+PRI_W+LEN_W +: COUNT_W];
            if (exp_wr == exp_rd) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result transfer: status %0d id %h pri %h",
                             got.status, got.head.id, got.head.pri,
                             " len %h count %0d", got.head.len, got.count);
            end else begin
                want = exp_results[exp_rd % EXP_SLOTS];
                exp_rd++;
                if (got.status !== want.status || got.head.id !== want.head.id ||
                    got.head.pri !== want.head.pri || got.head.len !== want.head.len ||
                    got.count !== want.count) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected status %0d id %h pri %h len %h count %0d,",
                                 want.status, want.head.id, want.head.pri, want.head.len,
                                 want.count,
                                 " got status %0d id %h pri %h len %h count %0d",
                                 got.status, got.head.id, got.head.pri,
                                 got.head.len, got.count);
                end
            end
        end
    end

    // watchdog on transfer activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin : stimulus
        int      push_pct;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_POP, 10'h000, 8'h00, 16'h0000, 1, 1'b1,
                srq_pkg::ST_EMPTY, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_PUSH, 10'h3ff, 8'hff, 16'hffff, 1, 1'b1,
                srq_pkg::ST_PUSHED, '0, '0, '0, 1);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_PUSH, 10'h000, 8'h00, 16'h0000, 1, 1'b1,
                srq_pkg::ST_PUSHED, '0, '0, '0, 2);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_PUSH, 10'h155, 8'hff, 16'h0064, 1, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_POP, 10'h3ff, 8'h00, 16'h0000, 1, 1'b1,
                srq_pkg::ST_POPPED, 10'h3ff, 8'hff, 16'hffff, 2);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_POP, 10'h000, 8'h00, 16'h0000, 2, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_POP, 10'h000, 8'h00, 16'h0000, 1, 1'b1,
                srq_pkg::ST_EMPTY, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_PUSH, 10'h100, 8'h07, 16'h1234, 16, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_PUSH, 10'h2aa, 8'h80, 16'h5555, 1, 1'b1,
                srq_pkg::ST_FULL, '0, '0, '0, 16);
        add_row(srq_pkg::SORT_LENGTH, srq_pkg::OP_POP, 10'h000, 8'h00, 16'h0000, 8, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_LENGTH, srq_pkg::OP_PUSH, 10'h200, 8'hff, 16'h0000, 1, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_LENGTH, srq_pkg::OP_PUSH, 10'h201, 8'h00, 16'hffff, 1, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_LENGTH, srq_pkg::OP_PUSH, 10'h210, 8'h11, 16'h0040, 5, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_LENGTH, srq_pkg::OP_PUSH, 10'h300, 8'h22, 16'h0040, 1, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_LENGTH, srq_pkg::OP_POP, 10'h000, 8'h00, 16'h0000, 16, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_LENGTH, srq_pkg::OP_POP, 10'h000, 8'h00, 16'h0000, 1, 1'b1,
                srq_pkg::ST_EMPTY, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_PUSH, 10'h3ff, 8'h00, 16'hffff, 1, 1'b1,
                srq_pkg::ST_PUSHED, '0, '0, '0, 1);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_PUSH, 10'h001, 8'hff, 16'h0000, 1, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_POP, 10'h000, 8'h00, 16'h0000, 2, 1'b0,
                srq_pkg::ST_PUSHED, '0, '0, '0, 0);
        add_row(srq_pkg::SORT_PRIORITY, srq_pkg::OP_POP, 10'h3ff, 8'hff, 16'hffff, 1, 1'b1,
                srq_pkg::ST_EMPTY, '0, '0, '0, 0);

        for (int r = 0; r < n_rows; r++) begin
            if (job_table[r].sort != order_key)
                set_order(job_table[r].sort);
            for (int k = 0; k < job_table[r].reps; k++)
                send_job(job_table[r].op, ID_W'(job_table[r].id + k),
                         PRI_W'(job_table[r].pri + k * 29),
                         LEN_W'(job_table[r].len + k * 4099),
                         job_table[r].typed, job_table[r].res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_order((ph % 2 == 0) ? srq_pkg::SORT_LENGTH : srq_pkg::SORT_PRIORITY);
            case ($urandom_range(3))
                0: push_pct = 25;
                1: push_pct = 50;
                2: push_pct = 75;
                default: push_pct = 92;
            endcase
            calm = (ph == 4);
            if (ph == 6) begin
                push_pct = 60;
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_random(push_pct);
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (5) @(posedge aclk);
        n_mismatch = n_mismatch + (exp_wr - exp_rd);
        if (n_mismatch == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
